/* src/ttr_pkg.sv */
package ttr_pkg;

	localparam int TIMER_COUNT_DEF = 8;
	localparam int TIME_BITS_DEF   = 16;

	localparam int KIND_W   = 2;
	localparam int DELAY_W  = 15;
	localparam int PERIOD_W = 15;
	localparam int HANDLE_W = 3;
	localparam int STATUS_W = 3;

	typedef enum logic [KIND_W-1:0] {
		KIND_SET      = 2'd0,
		KIND_DELETE   = 2'd1,
		KIND_TICK     = 2'd2,
		KIND_DISPATCH = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_ARMED   = 3'd0,
		STAT_REFUSED = 3'd1,
		STAT_DELETED = 3'd2,
		STAT_FIRED   = 3'd3,
		STAT_DONE    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SET,
		S_DREAD,
		S_DEVAL,
		S_RESP
	} state_t;

endpackage

/* src/ttr_req_if.sv */
interface ttr_req_if;
	logic                          valid;
	logic                          ready;
	logic [ttr_pkg::KIND_W-1:0]    kind;
	logic [ttr_pkg::DELAY_W-1:0]   delay;
	logic [ttr_pkg::PERIOD_W-1:0]  period;
	logic [ttr_pkg::HANDLE_W-1:0]  handle;
	logic                          has_action;

	modport source (output valid, kind, delay, period, handle, has_action, input ready);
	modport sink   (input valid, kind, delay, period, handle, has_action, output ready);
endinterface

/* src/ttr_rsp_if.sv */
interface ttr_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [ttr_pkg::STATUS_W-1:0]  status;
	logic [ttr_pkg::HANDLE_W-1:0]  handle_res;
	logic                          last;

	modport source (output valid, status, handle_res, last, input ready);
	modport sink   (input valid, status, handle_res, last, output ready);
endinterface

/* src/timer_table_with_periodic_reload.sv */
// Timer table with periodic reload.
// req (sink) carries one command beat: kind selects set, delete, tick or dispatch;
// delay/period/has_action matter for set, handle for delete.
// rsp (source) carries result beats: status, handle_res and last, which marks
// the final beat of a command. Tick gives no beat at all.
// Commands run on one sequencer walking the entry table one slot at a time
// through a single expiry/period memory port and one shared time adder:
//   tick      adds one to the time counter while idle and gives no beat.
//   delete    clears the armed bit, then gives its beat from the response step.
//   set       is refused when it has no action, else scans for the first free
//             entry and arms it, or is refused if no entry is free.
//   dispatch  reads each entry, evaluates each armed one, sends a fired beat
//             per expired entry, then ends with a done beat.
// req.ready is high only while the sequencer idles; one command at a time.
// Results leave through an output register, so a stalled receiver just holds
// the sequencer in its response step; no beat is dropped or repeated.
// Reset clears the armed bits and the time counter at once: every entry is
// free and the clock reads zero. Expiry and period storage needs no clearing,
// since an entry is only read while armed and arming writes both words.
module timer_table_with_periodic_reload #(
	parameter int TIMER_COUNT = ttr_pkg::TIMER_COUNT_DEF,
	parameter int TIME_BITS   = ttr_pkg::TIME_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ttr_req_if.sink    req,
	ttr_rsp_if.source  rsp
);

	localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
	localparam int TW    = TIME_BITS;
	localparam int HW    = ttr_pkg::HANDLE_W;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TIMER_COUNT - 1);

	// Sequencer state
	ttr_pkg::state_t  state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;

	// Command operands held across the scan
	logic [TW-1:0] delay_q;
	logic [TW-1:0] period_q;

	// Time counter and per-entry armed bits
	logic [TW-1:0]          now_q, now_d;
	logic [TIMER_COUNT-1:0] armed_q;

	// Entry storage: expiry and reload period, one port each, registered read
	logic [TW-1:0] exp_mem [TIMER_COUNT];
	logic [TW-1:0] per_mem [TIMER_COUNT];
	logic [TW-1:0] rd_exp_q;
	logic [TW-1:0] rd_per_q;

	// Pending result, waiting for the output register
	ttr_pkg::status_t res_status_q, res_status_d;
	logic [HW-1:0]    res_handle_q, res_handle_d;
	logic             res_last_q, res_last_d;

	// Output register
	logic                    out_valid_q;
	logic [ttr_pkg::STATUS_W-1:0] out_status_q;
	logic [HW-1:0]           out_handle_q;
	logic                    out_last_q;

	// Control strobes
	logic             accept;
	logic             out_free;
	logic             out_load;
	logic             at_end;
	logic             arm_we;
	logic [IDX_W-1:0] arm_idx;
	logic             arm_val;
	logic             exp_we;
	logic             per_we;
	logic [TW-1:0]    per_wdata;

	// Shared time adder and the expiry compare
	logic [TW-1:0] add_b;
	logic [TW-1:0] sum;
	logic [TW-1:0] diff;
	logic          expired;

	assign req.ready = (state_q == ttr_pkg::S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign at_end    = (idx_q == IDX_LAST);

	assign sum     = now_q + add_b;
	assign diff    = now_q - rd_exp_q;
	// expired when now is ahead of the expiry by less than half the range
	assign expired = (diff != '0) && !diff[TW-1];

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.handle_res = out_handle_q;
	assign rsp.last       = out_last_q;

	always_comb begin
		// pick the adder operand by step: tick adds one, set adds the delay,
		// a reload adds the stored period
		case (state_q)
			ttr_pkg::S_SET:   add_b = delay_q;
			ttr_pkg::S_DEVAL: add_b = rd_per_q;
			default:          add_b = TW'(1);
		endcase
	end

	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		now_d        = now_q;
		res_status_d = res_status_q;
		res_handle_d = res_handle_q;
		res_last_d   = res_last_q;
		out_load     = 1'b0;
		arm_we       = 1'b0;
		arm_idx      = idx_q;
		arm_val      = 1'b0;
		exp_we       = 1'b0;
		per_we       = 1'b0;
		per_wdata    = period_q;

		case (state_q)
			ttr_pkg::S_IDLE: begin
				if (accept) begin
					case (ttr_pkg::kind_t'(req.kind))
						ttr_pkg::KIND_SET: begin
							if (req.has_action) begin
								idx_d   = '0;
								state_d = ttr_pkg::S_SET;
							end else begin
								res_status_d = ttr_pkg::STAT_REFUSED;
								res_handle_d = '0;
								res_last_d   = 1'b1;
								state_d      = ttr_pkg::S_RESP;
							end
						end
						ttr_pkg::KIND_DELETE: begin
							// drop the entry only if the handle names one
							if (32'(req.handle) < 32'(TIMER_COUNT)) begin
								arm_we  = 1'b1;
								arm_idx = IDX_W'(req.handle);
								arm_val = 1'b0;
							end
							res_status_d = ttr_pkg::STAT_DELETED;
							res_handle_d = '0;
							res_last_d   = 1'b1;
							state_d      = ttr_pkg::S_RESP;
						end
						ttr_pkg::KIND_TICK: begin
							now_d = sum;
						end
						ttr_pkg::KIND_DISPATCH: begin
							idx_d   = '0;
							state_d = ttr_pkg::S_DREAD;
						end
						default: begin
							state_d = ttr_pkg::S_IDLE;
						end
					endcase
				end
			end

			ttr_pkg::S_SET: begin
				if (!armed_q[idx_q]) begin
					// arm the first free entry found
					arm_we       = 1'b1;
					arm_val      = 1'b1;
					exp_we       = 1'b1;
					per_we       = 1'b1;
					per_wdata    = period_q;
					res_status_d = ttr_pkg::STAT_ARMED;
					res_handle_d = HW'(idx_q);
					res_last_d   = 1'b1;
					state_d      = ttr_pkg::S_RESP;
				end else if (at_end) begin
					res_status_d = ttr_pkg::STAT_REFUSED;
					res_handle_d = '0;
					res_last_d   = 1'b1;
					state_d      = ttr_pkg::S_RESP;
				end else begin
					idx_d = idx_q + IDX_W'(1);
				end
			end

			ttr_pkg::S_DREAD: begin
				// storage read of idx_q lands at this edge
				if (armed_q[idx_q]) begin
					state_d = ttr_pkg::S_DEVAL;
				end else if (at_end) begin
					res_status_d = ttr_pkg::STAT_DONE;
					res_handle_d = '0;
					res_last_d   = 1'b1;
					state_d      = ttr_pkg::S_RESP;
				end else begin
					idx_d = idx_q + IDX_W'(1);
				end
			end

			ttr_pkg::S_DEVAL: begin
				if (expired) begin
					if (rd_per_q != '0) begin
						// periodic: reload relative to dispatch time
						exp_we = 1'b1;
					end else begin
						// one-shot: free the entry
						arm_we  = 1'b1;
						arm_val = 1'b0;
					end
					res_status_d = ttr_pkg::STAT_FIRED;
					res_handle_d = HW'(idx_q);
					res_last_d   = 1'b0;
					state_d      = ttr_pkg::S_RESP;
				end else if (at_end) begin
					res_status_d = ttr_pkg::STAT_DONE;
					res_handle_d = '0;
					res_last_d   = 1'b1;
					state_d      = ttr_pkg::S_RESP;
				end else begin
					idx_d   = idx_q + IDX_W'(1);
					state_d = ttr_pkg::S_DREAD;
				end
			end

			ttr_pkg::S_RESP: begin
				// hold the pending beat until the output register frees up
				if (out_free) begin
					out_load = 1'b1;
					if (res_last_q) begin
						state_d = ttr_pkg::S_IDLE;
					end else if (at_end) begin
						res_status_d = ttr_pkg::STAT_DONE;
						res_handle_d = '0;
						res_last_d   = 1'b1;
					end else begin
						idx_d   = idx_q + IDX_W'(1);
						state_d = ttr_pkg::S_DREAD;
					end
				end
			end

			default: begin
				state_d = ttr_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ttr_pkg::S_IDLE;
			idx_q       <= '0;
			now_q       <= '0;
			armed_q     <= '0;
			out_valid_q <= 1'b0;
			res_last_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			idx_q      <= idx_d;
			now_q      <= now_d;
			res_last_q <= res_last_d;
			if (arm_we) begin
				armed_q[arm_idx] <= arm_val;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		res_status_q <= res_status_d;
		res_handle_q <= res_handle_d;
		if (accept) begin
			delay_q  <= TW'(req.delay);
			period_q <= TW'(req.period);
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_handle_q <= res_handle_q;
			out_last_q   <= res_last_q;
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (exp_we) begin
			exp_mem[idx_q] <= sum;
		end
		if (per_we) begin
			per_mem[idx_q] <= per_wdata;
		end
		rd_exp_q <= exp_mem[idx_q];
		rd_per_q <= per_mem[idx_q];
	end

endmodule
